// ===== sv/odg4p_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package odg4p_pkg;

   // Register indexes on the configuration port.
   localparam logic [0:0] CSR_DITHER_ROWS_LOW  = 1'b0;
   localparam logic [0:0] CSR_DITHER_ROWS_HIGH = 1'b1;

   localparam int unsigned CSR_WIDTH  = 64;
   localparam int unsigned GRAY_SHIFT = 6;
   localparam logic [3:0]  GRAY_MAX   = 4'd15;
   localparam logic [1:0]  LAST_POS   = 2'd3;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [11:0] pixel_column;
      logic [11:0] pixel_row;
      logic        run_end;
   } req_type;

   typedef struct packed {
      logic [15:0] packed_word;
      logic        last_word;
   } rsp_type;

   // One classified pixel as it travels from the front end to the packer.
   typedef struct packed {
      logic [3:0] gray;
      logic [1:0] pos;
      logic       run_end;
   } entry_type;

endpackage

`default_nettype wire

// ===== sv/odg4p_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module odg4p_front (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_wr_en,
   input  wire [0:0]                          csr_index,
   input  wire [odg4p_pkg::CSR_WIDTH-1:0]     csr_wr_data,
   input  wire odg4p_pkg::req_type            req_data,
   output odg4p_pkg::entry_type               entry
);

   logic [odg4p_pkg::CSR_WIDTH-1:0] rows_low_ff;
   logic [odg4p_pkg::CSR_WIDTH-1:0] rows_high_ff;

   logic [3:0]         sel;
   logic [63:0]        row_pair;
   logic signed [7:0]  threshold;
   logic [9:0]         luma;
   logic signed [11:0] sum;
   logic [4:0]         coarse;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_low_ff  <= '0;
         rows_high_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            odg4p_pkg::CSR_DITHER_ROWS_LOW:  rows_low_ff  <= csr_wr_data;
            odg4p_pkg::CSR_DITHER_ROWS_HIGH: rows_high_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Dither entry is (row & 3) * 4 + (column & 3); rows 2 and 3 live in the high register.
   always_comb begin
      sel       = {req_data.pixel_row[1:0], req_data.pixel_column[1:0]};
      row_pair  = sel[3] ? rows_high_ff : rows_low_ff;
      threshold = signed'(row_pair[{sel[2:0], 3'b000} +: 8]);
      luma      = 10'(req_data.red) + {1'b0, req_data.green, 1'b0} + 10'(req_data.blue);
      sum       = signed'({2'b00, luma}) + 12'(threshold);
      if (sum < 0) begin
         coarse = '0;
      end else begin
         coarse = sum[10:6];
      end
      entry.gray    = (coarse > 5'(odg4p_pkg::GRAY_MAX)) ? odg4p_pkg::GRAY_MAX : coarse[3:0];
      entry.pos     = req_data.pixel_column[1:0];
      entry.run_end = req_data.run_end;
   end

endmodule

`default_nettype wire

// ===== sv/odg4p_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module odg4p_fifo #(
   parameter int unsigned DEPTH = 2
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  wire odg4p_pkg::entry_type  push_data,
   output logic                       full,
   output logic                       not_empty,
   input  wire                        pop,
   output odg4p_pkg::entry_type       pop_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   odg4p_pkg::entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      full      = (count_ff == CNT_W'(DEPTH));
      not_empty = (count_ff != '0);
      pop_data  = slots_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy beyond its depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ===== sv/odg4p_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module odg4p_back (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        entry_valid,
   input  wire odg4p_pkg::entry_type  entry,
   output logic                       entry_pop,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output odg4p_pkg::rsp_type         rsp_data
);

   logic [15:0]        partial_ff, partial_in;
   logic               rsp_valid_ff, rsp_valid_in;
   odg4p_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [15:0] merged;
   logic        emit;
   logic        out_free;

   always_comb begin
      // Nibble 0 goes to bits 15..12, nibble 3 to bits 3..0.
      merged   = partial_ff | ({entry.gray, 12'h000} >> {entry.pos, 2'b00});
      emit     = (entry.pos == odg4p_pkg::LAST_POS) || entry.run_end;
      out_free = !rsp_valid_ff || !rsp_stall;
      entry_pop = entry_valid && (!emit || out_free);

      partial_in   = partial_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (entry_pop) begin
         if (emit) begin
            partial_in              = '0;
            rsp_valid_in            = 1'b1;
            rsp_data_in.packed_word = merged;
            rsp_data_in.last_word   = entry.run_end;
         end else begin
            partial_in = merged;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         partial_ff   <= partial_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      (entry_pop && emit) |=> (partial_ff == '0))
      else $error("partial word not cleared after a word was sent");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (entry_pop && emit) |-> out_free)
      else $error("output register overwritten while a word is pending");

   a_new_word_source: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || !rsp_stall) ##1 rsp_valid_ff |-> $past(entry_pop && emit))
      else $error("word appeared without a popped pixel that ends it");

endmodule

`default_nettype wire

// ===== sv/ordered_dither_gray4_packer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted request is written into the pixel queue; the packer takes it from the queue
// head and registers any word it completes in the output register.
// Throughput: one request per cycle, held as long as the output side takes one word per cycle.
// The pixel queue between the threshold stage and the packer is QUEUE_DEPTH entries deep.
// Reset (synchronous, active high) clears both dither registers, the partial word,
// the queue and the output valid flag; no clearing pass is needed.

module ordered_dither_gray4_packer_unit #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire                                clock,
   input  wire                                reset,

   // Configuration write port; index 0 is dither rows 0 and 1, index 1 rows 2 and 3.
   input  wire                                csr_wr_en,
   input  wire [0:0]                          csr_index,
   input  wire [odg4p_pkg::CSR_WIDTH-1:0]     csr_wr_data,

   // Pixel request channel.
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire odg4p_pkg::req_type            req_data,

   // Packed word channel.
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output odg4p_pkg::rsp_type                 rsp_data
);

   odg4p_pkg::entry_type front_entry;
   odg4p_pkg::entry_type queue_head;
   logic                 queue_full;
   logic                 queue_not_empty;
   logic                 queue_pop;
   logic                 req_take;

   // The front end looks up the dither threshold for the pixel's place in the
   // 4x4 tile, adds it to the luma sum R+2G+B and clamps to a 4-bit gray level.
   odg4p_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .entry       (front_entry)
   );

   // The stall toward the requester depends only on the queue's registered
   // occupancy, so a stalled output never reaches back to the input combinationally.
   assign req_stall = queue_full;
   assign req_take  = req_valid && !queue_full;

   odg4p_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_take),
      .push_data (front_entry),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .pop       (queue_pop),
      .pop_data  (queue_head)
   );

   // The packer ORs each gray nibble into the partial word and sends the word
   // when the last nibble of a group is filled or the pixel ends a run.
   // Pixels that send nothing keep draining even while the output is stalled.
   odg4p_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (queue_not_empty),
      .entry       (queue_head),
      .entry_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// ===== verif/ordered_dither_gray4_packer_unit_tb.sv =====
`timescale 1ns / 1ps

module ordered_dither_gray4_packer_unit_tb;

   // A run is declared hung after this many cycles without any handshake on
   // either channel. The longest deliberate quiet stretch is the output
   // hold-off, so this leaves a wide margin.
   localparam int QUIET_LIMIT = 2000;
   // Cycles allowed after the last expected word before a register write or
   // the end of the run. A pixel that yields no word leaves the queue even while
   // the output is stalled, so it is out of the queue well within this.
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_ITEMS = 100;

   // The scoreboard keeps its own copy of the dither table and the partial
   // word. Every accepted request is turned into a gray nibble right away, and
   // a finished word goes into a queue that the output monitor drains in order.
   class gray_word_board;
      logic [63:0]        rows_low;
      logic [63:0]        rows_high;
      logic [15:0]        partial;
      odg4p_pkg::rsp_type words_due[$];
      int                 mismatches;

      function new();
         rows_low   = '0;
         rows_high  = '0;
         partial    = '0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [0:0] index, logic [63:0] value);
         if (index == odg4p_pkg::CSR_DITHER_ROWS_LOW) begin
            rows_low = value;
         end else begin
            rows_high = value;
         end
      endfunction

      function logic [3:0] gray_of(odg4p_pkg::req_type p);
         logic [3:0]        entry;
         logic [63:0]       bank;
         logic signed [7:0] threshold;
         int                level;
         entry     = {p.pixel_row[1:0], p.pixel_column[1:0]};
         bank      = entry[3] ? rows_high : rows_low;
         threshold = bank[entry[2:0] * 8 +: 8];
         level     = int'(p.red) + 2 * int'(p.green) + int'(p.blue) + int'(threshold);
         if (level < 0) begin
            level = 0;
         end
         level = level >> odg4p_pkg::GRAY_SHIFT;
         if (level > odg4p_pkg::GRAY_MAX) begin
            return odg4p_pkg::GRAY_MAX;
         end
         return level[3:0];
      endfunction

      function void note_pixel(odg4p_pkg::req_type p);
         int                 slot;
         odg4p_pkg::rsp_type word;
         slot = 3 - int'(p.pixel_column[1:0]);
         partial[slot * 4 +: 4] = partial[slot * 4 +: 4] | gray_of(p);
         if (p.pixel_column[1:0] == odg4p_pkg::LAST_POS || p.run_end) begin
            word.packed_word = partial;
            word.last_word   = p.run_end;
            words_due.push_back(word);
            partial = '0;
         end
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_word(odg4p_pkg::rsp_type got);
         odg4p_pkg::rsp_type want;
         if (words_due.size() == 0) begin
            report($sformatf("word %h last %b with nothing expected",
                             got.packed_word, got.last_word));
            return;
         end
         want = words_due.pop_front();
         if (got.packed_word !== want.packed_word) begin
            report($sformatf("packed_word %h, expected %h", got.packed_word, want.packed_word));
         end
         if (got.last_word !== want.last_word) begin
            report($sformatf("last_word %b, expected %b", got.last_word, want.last_word));
         end
      endtask

      function int pending();
         return words_due.size();
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_wr_en;
   logic [0:0]                      csr_index;
   logic [odg4p_pkg::CSR_WIDTH-1:0] csr_wr_data;
   logic                            req_valid;
   logic                            req_stall;
   odg4p_pkg::req_type              req_data;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   odg4p_pkg::rsp_type              rsp_data;

   gray_word_board board;

   // Idle rates in percent for the sender and the receiver, set per phase.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // Raised by the stimulus to ask the receiver for one long hold-off.
   bit hold_request  = 1'b0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   ordered_dither_gray4_packer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   always #5 clock = ~clock;

   // The receiver decides its stall at the falling edge so that it is stable
   // at the rising edge. A long hold-off is counted here, in its own process,
   // while the sender keeps offering requests and the block backs up.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = 79;
         rsp_stall    = 1'b1;
      end else begin
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Output monitor and quiet-cycle counter. Outputs are sampled at the
   // rising edge, before the block's own updates for that edge land.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_word(rsp_data);
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
   end

   // Watchdog: a hang ends the run as a failure.
   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
      end
      $display("simulation failed");
      $finish;
   end

   function automatic odg4p_pkg::req_type pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                                logic [11:0] col, logic [11:0] row,
                                                logic last);
      odg4p_pkg::req_type p;
      p.red          = r;
      p.green        = g;
      p.blue         = b;
      p.pixel_column = col;
      p.pixel_row    = row;
      p.run_end      = last;
      return p;
   endfunction

   // Color components lean toward the extremes now and then, so that both
   // the floor at zero and the saturation at full scale come up often.
   function automatic logic [7:0] shade();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Offers one request and returns at the falling edge after it was taken.
   // Every call starts and ends at a falling edge with valid low, so a
   // request is never offered twice.
   task automatic send_pixel(odg4p_pkg::req_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = p;
      do begin
         @(posedge clock);
      end while (req_stall);
      board.note_pixel(p);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // A well-formed run: consecutive columns on one row, starting anywhere in
   // a word, closed by a run end. One run in ten is left open on purpose.
   task automatic send_run(inout int count);
      logic [11:0] col;
      logic [11:0] row;
      int          len;
      bit          closed;
      col    = 12'($urandom_range(4095));
      row    = 12'($urandom_range(4095));
      len    = $urandom_range(1, 10);
      closed = ($urandom_range(9) != 0);
      for (int i = 0; i < len; i++) begin
         send_pixel(pixel(shade(), shade(), shade(), col, row, closed && (i == len - 1)));
         col++;
      end
      count += len;
   endtask

   // Waits for every expected word, then lets the pipeline empty out so that
   // a pixel without a word of its own is out of the queue.
   task automatic settle();
      while (board.pending() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes both dither registers; only called while the block is idle.
   task automatic write_dither(logic [63:0] low_rows, logic [63:0] high_rows);
      csr_wr_en   = 1'b1;
      csr_index   = odg4p_pkg::CSR_DITHER_ROWS_LOW;
      csr_wr_data = low_rows;
      @(negedge clock);
      board.write_reg(odg4p_pkg::CSR_DITHER_ROWS_LOW, low_rows);
      csr_index   = odg4p_pkg::CSR_DITHER_ROWS_HIGH;
      csr_wr_data = high_rows;
      @(negedge clock);
      board.write_reg(odg4p_pkg::CSR_DITHER_ROWS_HIGH, high_rows);
      csr_wr_en   = 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int items;
      bit paused;
      board       = new();
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_index   = odg4p_pkg::CSR_DITHER_ROWS_LOW;
      csr_wr_data = '0;
      req_valid   = 1'b0;
      req_data    = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // With the reset table all thresholds are zero.
      send_pixel(pixel(8'd100, 8'd50, 8'd30, 12'd3, 12'd0, 1'b1));
      settle();

      // Directed part. Rows 0 and 1 get the largest positive threshold,
      // rows 2 and 3 the most negative one.
      write_dither({8{8'h7F}}, {8{8'h80}});
      // One full word: small sum lifted by the threshold, full scale that
      // saturates past 15, a sum pushed below zero, and a strong negative
      // threshold on a bright pixel.
      send_pixel(pixel(8'h00, 8'h00, 8'h00, 12'd0, 12'd0, 1'b0));
      send_pixel(pixel(8'hFF, 8'hFF, 8'hFF, 12'd1, 12'd0, 1'b0));
      send_pixel(pixel(8'h00, 8'h00, 8'h00, 12'd2, 12'd2, 1'b0));
      send_pixel(pixel(8'hFF, 8'hFF, 8'hFF, 12'd3, 12'd3, 1'b0));
      // A run that starts in the middle of a word leaves the left nibbles zero.
      send_pixel(pixel(8'h80, 8'h40, 8'hC0, 12'h0FE, 12'd1, 1'b0));
      send_pixel(pixel(8'h12, 8'hEE, 8'h34, 12'h0FF, 12'd1, 1'b0));
      // The last nibble and the run end on the same pixel give one word.
      send_pixel(pixel(8'hFF, 8'h00, 8'hFF, 12'hFFC, 12'hFFF, 1'b0));
      send_pixel(pixel(8'h00, 8'hFF, 8'h00, 12'hFFD, 12'hFFF, 1'b0));
      send_pixel(pixel(8'hAA, 8'h55, 8'hAA, 12'hFFE, 12'hFFF, 1'b0));
      send_pixel(pixel(8'hFF, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF, 1'b1));
      // A repeated column merges into the same nibble.
      send_pixel(pixel(8'h40, 8'h00, 8'h00, 12'd8, 12'd0, 1'b0));
      send_pixel(pixel(8'h00, 8'h00, 8'hC0, 12'd8, 12'd0, 1'b0));
      send_pixel(pixel(8'h70, 8'h70, 8'h70, 12'd9, 12'd1, 1'b1));
      // A skipped column stays zero in the word.
      send_pixel(pixel(8'hFF, 8'hFF, 8'hFF, 12'd16, 12'd0, 1'b0));
      send_pixel(pixel(8'h60, 8'h90, 8'h30, 12'd18, 12'd0, 1'b0));
      send_pixel(pixel(8'h01, 8'h02, 8'h03, 12'd19, 12'd2, 1'b0));
      // Runs that end on the first and the second nibble.
      send_pixel(pixel(8'hFF, 8'hFF, 8'hFF, 12'd20, 12'd0, 1'b1));
      send_pixel(pixel(8'h33, 8'hCC, 8'h33, 12'hAA9, 12'hFFF, 1'b1));
      settle();

      // Random phases. The receiver idles more in the first two, the sender
      // in the next two, and neither in the last two.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            // Classic Bayer ordering, scaled to span roughly two gray steps.
            0: write_dither(64'hF030_E020_10D0_00C0, 64'hE828_F838_08C8_18D8);
            2: write_dither(64'h0, {8{8'hFF}});
            4: write_dither({8{8'h80}}, {8{8'h7F}});
            default: write_dither({$urandom, $urandom}, {$urandom, $urandom});
         endcase
         send_idle_pct = (ph < 2) ? 19 : (ph < 4) ? 58 : 0;
         recv_idle_pct = (ph < 2) ? 58 : (ph < 4) ? 19 : 0;
         // In the first phase without idling the receiver holds off for a
         // long stretch while requests keep coming, so the input stalls.
         if (ph == 4) begin
            hold_request = 1'b1;
         end
         items  = 0;
         paused = 1'b0;
         while (items < PHASE_ITEMS) begin
            // Once, the sender stops until every expected word has come out.
            if (ph == 2 && items >= PHASE_ITEMS / 2 && !paused) begin
               paused = 1'b1;
               while (board.pending() != 0) begin
                  @(negedge clock);
               end
            end
            if ($urandom_range(99) < 80) begin
               send_run(items);
            end else begin
               // Noise: any column and row, so that columns repeat and skip.
               send_pixel(pixel(shade(), shade(), shade(), 12'($urandom),
                                12'($urandom), ($urandom_range(99) < 30)));
               items++;
            end
         end
         settle();
      end

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
